// ===== sv/hdp_pkg.sv =====
// ----------------------------------------------------------------------------
// hdp_pkg: shared types and constants for the http date parser
// parse positions, month codes, letter tables and result widths
// ----------------------------------------------------------------------------
package hdp_pkg;

    localparam int PosW  = 6;
    localparam int SecsW = 33;

    localparam logic [PosW-1:0] P_SKIP   = 6'd0;
    localparam logic [PosW-1:0] P_DAY1   = 6'd1;
    localparam logic [PosW-1:0] P_DAY2   = 6'd2;
    localparam logic [PosW-1:0] P_DAYSEP = 6'd3;
    localparam logic [PosW-1:0] P_MON0   = 6'd4;
    localparam logic [PosW-1:0] P_MA2    = 6'd5;
    localparam logic [PosW-1:0] P_MJ2    = 6'd6;
    localparam logic [PosW-1:0] P_MJU    = 6'd7;
    localparam logic [PosW-1:0] P_MM2    = 6'd8;
    localparam logic [PosW-1:0] P_M2ND   = 6'd9;
    localparam logic [PosW-1:0] P_M3RD   = 6'd10;
    localparam logic [PosW-1:0] P_MSEP   = 6'd11;
    localparam logic [PosW-1:0] P_MOPTSP = 6'd12;
    localparam logic [PosW-1:0] P_FIELD1 = 6'd13;
    localparam logic [PosW-1:0] P_AD2    = 6'd14;
    localparam logic [PosW-1:0] P_Y2     = 6'd15;
    localparam logic [PosW-1:0] P_Y3     = 6'd16;
    localparam logic [PosW-1:0] P_Y4     = 6'd17;
    localparam logic [PosW-1:0] P_NEEDSP = 6'd18;
    localparam logic [PosW-1:0] P_H1     = 6'd19;
    localparam logic [PosW-1:0] P_H2     = 6'd20;
    localparam logic [PosW-1:0] P_C1     = 6'd21;
    localparam logic [PosW-1:0] P_MI1    = 6'd22;
    localparam logic [PosW-1:0] P_MI2    = 6'd23;
    localparam logic [PosW-1:0] P_C2     = 6'd24;
    localparam logic [PosW-1:0] P_S1     = 6'd25;
    localparam logic [PosW-1:0] P_S2     = 6'd26;
    localparam logic [PosW-1:0] P_TSP    = 6'd27;
    localparam logic [PosW-1:0] P_AY1    = 6'd28;
    localparam logic [PosW-1:0] P_AY2    = 6'd29;
    localparam logic [PosW-1:0] P_AY3    = 6'd30;
    localparam logic [PosW-1:0] P_AY4    = 6'd31;
    localparam logic [PosW-1:0] P_MM3    = 6'd32;

    localparam logic [1:0] OUT_PENDING = 2'd0;
    localparam logic [1:0] OUT_DONE    = 2'd1;
    localparam logic [1:0] OUT_FAILED  = 2'd2;

    // month codes, march first
    localparam logic [3:0] M_MAR = 4'd1;
    localparam logic [3:0] M_APR = 4'd2;
    localparam logic [3:0] M_MAY = 4'd3;
    localparam logic [3:0] M_JUN = 4'd4;
    localparam logic [3:0] M_JUL = 4'd5;
    localparam logic [3:0] M_AUG = 4'd6;
    localparam logic [3:0] M_SEP = 4'd7;
    localparam logic [3:0] M_OCT = 4'd8;
    localparam logic [3:0] M_NOV = 4'd9;
    localparam logic [3:0] M_DEC = 4'd10;
    localparam logic [3:0] M_JAN = 4'd11;
    localparam logic [3:0] M_FEB = 4'd12;

    localparam logic [18:0] EpochOffset = 19'd0;
    localparam logic [25:0] DayBias     = 26'd60652800;

    typedef logic [7:0]       char_t;
    typedef logic [SecsW-1:0] secs_t;

    function automatic char_t second_letter(input logic [3:0] m);
        case (m)
            M_SEP:   second_letter = "e";
            M_OCT:   second_letter = "c";
            M_NOV:   second_letter = "o";
            M_DEC:   second_letter = "e";
            M_FEB:   second_letter = "e";
            default: second_letter = 8'd0;
        endcase
    endfunction

    function automatic char_t third_letter(input logic [3:0] m);
        case (m)
            M_APR:   third_letter = "r";
            M_AUG:   third_letter = "g";
            M_SEP:   third_letter = "p";
            M_OCT:   third_letter = "t";
            M_NOV:   third_letter = "v";
            M_DEC:   third_letter = "c";
            M_JAN:   third_letter = "n";
            M_FEB:   third_letter = "b";
            default: third_letter = 8'd0;
        endcase
    endfunction

    // floor(m * 520 / 17)
    function automatic logic [8:0] month_days(input logic [3:0] m);
        case (m)
            4'd0:    month_days = 9'd0;
            4'd1:    month_days = 9'd30;
            4'd2:    month_days = 9'd61;
            4'd3:    month_days = 9'd91;
            4'd4:    month_days = 9'd122;
            4'd5:    month_days = 9'd152;
            4'd6:    month_days = 9'd183;
            4'd7:    month_days = 9'd214;
            4'd8:    month_days = 9'd244;
            4'd9:    month_days = 9'd275;
            4'd10:   month_days = 9'd305;
            4'd11:   month_days = 9'd336;
            4'd12:   month_days = 9'd367;
            4'd13:   month_days = 9'd397;
            4'd14:   month_days = 9'd428;
            default: month_days = 9'd458;
        endcase
    endfunction

endpackage

// ===== sv/hdp_if.sv =====
// ----------------------------------------------------------------------------
// hdp_char_if / hdp_res_if: valid-ready channels of the http date parser
// one character per item in, one epoch result per item out
// ----------------------------------------------------------------------------
interface hdp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;
    modport source (output valid, output char_code, output is_last, input ready);
    modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface hdp_res_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] epoch_seconds;
    logic               valid_res;
    modport source (output valid, output epoch_seconds, output valid_res, input ready);
    modport sink (input valid, input epoch_seconds, input valid_res, output ready);
endinterface

// ===== sv/http_date_to_epoch_parser.sv =====
// ----------------------------------------------------------------------------
// http_date_to_epoch_parser: http date string to unix seconds
// parses rfc 1123, rfc 850 and asctime dates one character per item
// ----------------------------------------------------------------------------
// throughput: one character item per cycle while the capture stage is ready (it stalls on res_out.ready)
// path: the result item for a last character is registered in turn in the capture stage,
//   the day-count stage and the seconds stage with its multiplier, and then leaves
// reset: parser returns to the skip-to-first-space phase, all stages empty
// every stage moves when the one after it is empty or moving
module http_date_to_epoch_parser
    import hdp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    hdp_char_if.sink      char_in,
    hdp_res_if.source     res_out
);

    // ------------------------------------------------------------------
    // parser state
    // ------------------------------------------------------------------
    logic [PosW-1:0] pos_reg, pos_next;
    logic [6:0]      day_reg, day_next;
    logic            day_seen_reg, day_seen_next;
    logic [3:0]      mon_reg, mon_next;
    logic [13:0]     year_reg, year_next;
    logic            year_seen_reg, year_seen_next;
    logic [18:0]     sec_reg, sec_next;
    logic [1:0]      outc_reg, outc_next;

    logic            accept;
    logic            s1_ready, s2_ready, s3_ready;

    char_t           c;
    logic            dig;
    logic [3:0]      d;
    logic            is_sep;     // space or dash
    logic            mfirst;     // month first letter at this position
    logic            ffirst;     // day or year field start at this position

    assign c      = char_in.char_code;
    assign dig    = (c >= "0") && (c <= "9");
    assign d      = c[3:0];
    assign is_sep = (c == " ") || (c == "-");
    assign accept = char_in.valid && char_in.ready;
    assign char_in.ready = s1_ready;

    always_comb
    begin
        pos_next       = pos_reg;
        day_next       = day_reg;
        day_seen_next  = day_seen_reg;
        mon_next       = mon_reg;
        year_next      = year_reg;
        year_seen_next = year_seen_reg;
        sec_next       = sec_reg;
        outc_next      = outc_reg;
        mfirst         = 1'b0;
        ffirst         = 1'b0;
        if (outc_reg == OUT_PENDING)
        begin
            case (pos_reg)
                P_SKIP:
                begin
                    if (c == " ") pos_next = P_DAY1;
                    else if (c == 8'd0) outc_next = OUT_FAILED;
                end
                P_DAY1:
                begin
                    if (dig)
                    begin
                        day_next      = {3'd0, d};
                        day_seen_next = 1'b1;
                        pos_next      = P_DAY2;
                    end
                    else mfirst = 1'b1;
                end
                P_DAY2:
                begin
                    if (dig)
                    begin
                        day_next = 7'(day_reg * 7'd10 + {3'd0, d});
                        pos_next = P_DAYSEP;
                    end
                    else if (is_sep) pos_next = P_MON0;
                    else outc_next = OUT_FAILED;
                end
                P_DAYSEP:
                begin
                    if (is_sep) pos_next = P_MON0;
                    else outc_next = OUT_FAILED;
                end
                P_MON0: mfirst = 1'b1;
                P_MA2:
                begin
                    if (c == "p") begin mon_next = M_APR; pos_next = P_M3RD; end
                    else if (c == "u") begin mon_next = M_AUG; pos_next = P_M3RD; end
                    else outc_next = OUT_FAILED;
                end
                P_MJ2:
                begin
                    if (c == "a") begin mon_next = M_JAN; pos_next = P_M3RD; end
                    else if (c == "u") pos_next = P_MJU;
                    else outc_next = OUT_FAILED;
                end
                P_MJU:
                begin
                    if (c == "n") begin mon_next = M_JUN; pos_next = P_MSEP; end
                    else if (c == "l") begin mon_next = M_JUL; pos_next = P_MSEP; end
                    else outc_next = OUT_FAILED;
                end
                P_MM2:
                begin
                    if (c == "a") pos_next = P_MM3;
                    else outc_next = OUT_FAILED;
                end
                P_MM3:
                begin
                    if (c == "r") begin mon_next = M_MAR; pos_next = P_MSEP; end
                    else if (c == "y") begin mon_next = M_MAY; pos_next = P_MSEP; end
                    else outc_next = OUT_FAILED;
                end
                P_M2ND:
                begin
                    if (c == second_letter(mon_reg)) pos_next = P_M3RD;
                    else outc_next = OUT_FAILED;
                end
                P_M3RD:
                begin
                    if (c == third_letter(mon_reg)) pos_next = P_MSEP;
                    else outc_next = OUT_FAILED;
                end
                P_MSEP:
                begin
                    if (is_sep) pos_next = P_MOPTSP;
                    else outc_next = OUT_FAILED;
                end
                P_MOPTSP:
                begin
                    if (c == " ") pos_next = P_FIELD1;
                    else ffirst = 1'b1;
                end
                P_FIELD1: ffirst = 1'b1;
                P_AD2:
                begin
                    if (dig)
                    begin
                        day_next = 7'(day_reg * 7'd10 + {3'd0, d});
                        pos_next = P_NEEDSP;
                    end
                    else if (c == " ") pos_next = P_H1;
                    else outc_next = OUT_FAILED;
                end
                P_Y2, P_Y3, P_Y4:
                begin
                    if (dig)
                    begin
                        year_next = 14'(year_reg * 14'd10 + {10'd0, d});
                        pos_next  = (pos_reg == P_Y2) ? P_Y3 :
                                    (pos_reg == P_Y3) ? P_Y4 : P_NEEDSP;
                    end
                    else if (c == " ") pos_next = P_H1;
                    else outc_next = OUT_FAILED;
                end
                P_NEEDSP:
                begin
                    if (c == " ") pos_next = P_H1;
                    else outc_next = OUT_FAILED;
                end
                P_H1, P_H2, P_MI1, P_MI2, P_S1, P_S2:
                begin
                    if (dig)
                    begin
                        case (pos_reg)
                            P_H1:
                            begin
                                sec_next = 19'(sec_reg + d * 19'd36000);
                                pos_next = P_H2;
                            end
                            P_H2:
                            begin
                                sec_next = 19'(sec_reg + d * 19'd3600);
                                pos_next = P_C1;
                            end
                            P_MI1:
                            begin
                                sec_next = 19'(sec_reg + d * 19'd600);
                                pos_next = P_MI2;
                            end
                            P_MI2:
                            begin
                                sec_next = 19'(sec_reg + d * 19'd60);
                                pos_next = P_C2;
                            end
                            P_S1:
                            begin
                                sec_next = 19'(sec_reg + d * 19'd10);
                                pos_next = P_S2;
                            end
                            default:
                            begin
                                sec_next = 19'(sec_reg + {15'd0, d});
                                pos_next = P_TSP;
                            end
                        endcase
                    end
                    else outc_next = OUT_FAILED;
                end
                P_C1:
                begin
                    if (c == ":") pos_next = P_MI1;
                    else outc_next = OUT_FAILED;
                end
                P_C2:
                begin
                    if (c == ":") pos_next = P_S1;
                    else outc_next = OUT_FAILED;
                end
                P_TSP:
                begin
                    if (c != " ") outc_next = OUT_FAILED;
                    else if (year_seen_reg) outc_next = OUT_DONE;
                    else
                    begin
                        year_next = 14'd0;
                        pos_next  = P_AY1;
                    end
                end
                P_AY1, P_AY2, P_AY3, P_AY4:
                begin
                    if (dig)
                    begin
                        case (pos_reg)
                            P_AY1:
                            begin
                                year_next = 14'(year_reg + d * 14'd1000);
                                pos_next  = P_AY2;
                            end
                            P_AY2:
                            begin
                                year_next = 14'(year_reg + d * 14'd100);
                                pos_next  = P_AY3;
                            end
                            P_AY3:
                            begin
                                year_next = 14'(year_reg + d * 14'd10);
                                pos_next  = P_AY4;
                            end
                            default:
                            begin
                                year_next = 14'(year_reg + {10'd0, d});
                                outc_next = OUT_DONE;
                            end
                        endcase
                    end
                    else outc_next = OUT_FAILED;
                end
                default: outc_next = OUT_FAILED;
            endcase

            // first letter of the month
            if (mfirst)
            begin
                case (c)
                    "A": pos_next = P_MA2;
                    "J": pos_next = P_MJ2;
                    "M": pos_next = P_MM2;
                    "D": begin mon_next = M_DEC; pos_next = P_M2ND; end
                    "F": begin mon_next = M_FEB; pos_next = P_M2ND; end
                    "N": begin mon_next = M_NOV; pos_next = P_M2ND; end
                    "O": begin mon_next = M_OCT; pos_next = P_M2ND; end
                    "S": begin mon_next = M_SEP; pos_next = P_M2ND; end
                    default: outc_next = OUT_FAILED;
                endcase
            end

            // year after a leading day, else the asctime day
            if (ffirst)
            begin
                if (!dig) outc_next = OUT_FAILED;
                else if (day_seen_reg)
                begin
                    year_next      = {10'd0, d};
                    year_seen_next = 1'b1;
                    pos_next       = P_Y2;
                end
                else
                begin
                    day_next = {3'd0, d};
                    pos_next = P_AD2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= P_SKIP;
            day_reg       <= 7'd0;
            day_seen_reg  <= 1'b0;
            mon_reg       <= 4'd0;
            year_reg      <= 14'd0;
            year_seen_reg <= 1'b0;
            sec_reg       <= 19'd0;
            outc_reg      <= OUT_PENDING;
        end
        else if (accept)
        begin
            if (char_in.is_last)
            begin
                // string ends: back to the start for the next one
                pos_reg       <= P_SKIP;
                day_reg       <= 7'd0;
                day_seen_reg  <= 1'b0;
                mon_reg       <= 4'd0;
                year_reg      <= 14'd0;
                year_seen_reg <= 1'b0;
                sec_reg       <= 19'd0;
                outc_reg      <= OUT_PENDING;
            end
            else
            begin
                pos_reg       <= pos_next;
                day_reg       <= day_next;
                day_seen_reg  <= day_seen_next;
                mon_reg       <= mon_next;
                year_reg      <= year_next;
                year_seen_reg <= year_seen_next;
                sec_reg       <= sec_next;
                outc_reg      <= outc_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: capture the finished fields of a last item
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic        s1_done_reg;
    logic [13:0] s1_year_reg;
    logic [3:0]  s1_mon_reg;
    logic [6:0]  s1_day_reg;
    logic [18:0] s1_sec_reg;

    assign s1_ready = !s1_valid_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= accept && char_in.is_last;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && accept && char_in.is_last)
        begin
            s1_done_reg <= (outc_next == OUT_DONE);
            s1_year_reg <= year_next;
            s1_mon_reg  <= mon_next;
            s1_day_reg  <= day_next;
            s1_sec_reg  <= sec_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: year window and day count
    // ------------------------------------------------------------------
    logic        yr_ok;
    logic [6:0]  yr_map;      // 2..101 when in a window
    logic [6:0]  yr_adj;
    logic [15:0] days_calc;

    always_comb
    begin
        yr_ok  = 1'b1;
        yr_map = 7'd0;
        if (s1_year_reg < 14'd70)
            yr_map = 7'(s1_year_reg + 14'd32);
        else if (s1_year_reg < 14'd100)
            yr_map = 7'(s1_year_reg - 14'd68);
        else if (s1_year_reg < 14'd1970)
            yr_ok = 1'b0;
        else if (s1_year_reg < 14'd2040)
            yr_map = 7'(s1_year_reg - 14'd1968);
        else
            yr_ok = 1'b0;
        // january and february count with the year before
        yr_adj    = (s1_mon_reg > M_DEC) ? 7'(yr_map - 7'd1) : yr_map;
        days_calc = 16'(yr_adj * 16'd365) + 16'(yr_adj[6:2])
                  + 16'(month_days(s1_mon_reg)) + 16'(s1_day_reg);
    end

    logic        s2_valid_reg;
    logic        s2_ok_reg;
    logic [15:0] s2_days_reg;
    logic [18:0] s2_sec_reg;

    assign s2_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_ok_reg   <= s1_done_reg && yr_ok;
            s2_days_reg <= days_calc;
            s2_sec_reg  <= s1_sec_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: seconds, held in the output register
    // ------------------------------------------------------------------
    logic [33:0] secs_calc;
    logic        out_valid_reg;
    secs_t       out_secs_reg;
    logic        out_ok_reg;

    assign secs_calc = 34'(s2_days_reg * 34'd86400) + 34'(s2_sec_reg)
                     + 34'(EpochOffset) - 34'(DayBias);
    assign s3_ready  = !out_valid_reg || res_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s3_ready)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            out_ok_reg   <= s2_ok_reg;
            out_secs_reg <= s2_ok_reg ? secs_calc[SecsW-1:0] : '0;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.epoch_seconds = out_secs_reg;
    assign res_out.valid_res     = out_ok_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.valid_res |-> res_out.epoch_seconds == '0)
        else $error("rejected date carries nonzero seconds");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && char_in.is_last |=> pos_reg == P_SKIP && outc_reg == OUT_PENDING)
        else $error("parser did not restart after last item");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |-> !char_in.ready)
        else $error("item taken while capture stage is blocked");

endmodule
